>>> hdl/smss_pkg.sv
// shared types, constants and mux decode function for the sensor matrix scan sequencer
package smss_pkg;

    localparam int CNT_W         = 5;
    localparam int LINES_W       = 8;
    localparam int SAMPLE_W      = 12;
    localparam int MUX_A_CHANNELS = 16;
    localparam int MUX_CHANNELS  = 20;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_WAIT  = 2'd2,
        PH_DONE  = 2'd3
    } smss_phase_t;

    // scan state carried from tick to tick
    typedef struct packed {
        smss_phase_t          phase;
        logic [CNT_W-1:0]     col_count;
        logic [CNT_W-1:0]     row_count;
        logic                 done_pending;
        logic [LINES_W-1:0]   col_lines;
        logic [LINES_W-1:0]   row_lines;
    } smss_state_t;

    // one result item
    typedef struct packed {
        logic [LINES_W-1:0]   col_mux_lines;
        logic [LINES_W-1:0]   row_mux_lines;
        logic                 adc_start;
        logic                 sample_valid;
        logic [SAMPLE_W-1:0]  sample_value;
        logic [CNT_W-1:0]     col_index;
        logic [CNT_W-1:0]     row_index;
        logic                 frame_last;
    } smss_result_t;

    // channel onto one mux pair: enA low for 0..15, enB low for 16..19,
    // select of the disabled half keeps its level, out of range keeps all
    function automatic logic [LINES_W-1:0] mux_decode(
        input logic [LINES_W-1:0] lines,
        input logic [CNT_W-1:0]   chan
    );
        logic [CNT_W-1:0]   offs;
        logic [LINES_W-1:0] res;
        offs = chan - CNT_W'(MUX_A_CHANNELS);
        if (chan < CNT_W'(MUX_A_CHANNELS))
        begin
            res = {2'b01, lines[5:4], chan[3:0]};
        end
        else if (chan < CNT_W'(MUX_CHANNELS))
        begin
            res = {2'b10, offs[1:0], lines[3:0]};
        end
        else
        begin
            res = lines;
        end
        return res;
    endfunction

endpackage

>>> hdl/smss_step.sv
// next-state and result logic for one scan tick
module smss_step #(
    parameter int MATRIX_DIM = 20
) (
    input  smss_pkg::smss_state_t                 cur,
    input  logic                                  conv_done,
    input  logic [smss_pkg::SAMPLE_W-1:0]         adc_sample,
    output smss_pkg::smss_state_t                 nxt,
    output smss_pkg::smss_result_t                res
);

    localparam logic [smss_pkg::CNT_W-1:0] LAST_IDX = smss_pkg::CNT_W'(MATRIX_DIM - 1);

    logic col_at_end;
    logic row_at_end;
    logic pending_or_done;
    smss_pkg::smss_phase_t phase_next;

    assign col_at_end      = (cur.col_count >= LAST_IDX);
    assign row_at_end      = (cur.row_count >= LAST_IDX);
    assign pending_or_done = cur.done_pending | conv_done;

    // next phase
    always_comb
    begin
        phase_next = cur.phase;
        unique case (cur.phase)
            smss_pkg::PH_IDLE:  phase_next = smss_pkg::PH_START;
            smss_pkg::PH_START: phase_next = smss_pkg::PH_WAIT;
            smss_pkg::PH_WAIT:
            begin
                if (pending_or_done)
                begin
                    phase_next = smss_pkg::PH_DONE;
                end
            end
            smss_pkg::PH_DONE:  phase_next = smss_pkg::PH_IDLE;
            default:            phase_next = smss_pkg::PH_IDLE;
        endcase
    end

    // counters, pending flag, mux lines and result fields
    always_comb
    begin
        nxt.phase        = phase_next;
        nxt.col_count    = cur.col_count;
        nxt.row_count    = cur.row_count;
        nxt.done_pending = pending_or_done;
        nxt.col_lines    = cur.col_lines;
        nxt.row_lines    = cur.row_lines;
        res.adc_start    = 1'b0;
        res.sample_valid = 1'b0;
        res.sample_value = '0;
        res.col_index    = '0;
        res.row_index    = '0;
        res.frame_last   = 1'b0;
        unique case (cur.phase)
            smss_pkg::PH_IDLE:
            begin
                nxt.col_lines = smss_pkg::mux_decode(cur.col_lines, cur.col_count);
                if (cur.col_count == '0)
                begin
                    nxt.row_lines = smss_pkg::mux_decode(cur.row_lines, cur.row_count);
                end
            end
            smss_pkg::PH_START:
            begin
                nxt.done_pending = 1'b0;
                res.adc_start    = 1'b1;
            end
            smss_pkg::PH_WAIT:
            begin
                nxt.done_pending = pending_or_done;
            end
            smss_pkg::PH_DONE:
            begin
                res.sample_valid = 1'b1;
                res.sample_value = adc_sample;
                res.col_index    = cur.col_count;
                res.row_index    = cur.row_count;
                res.frame_last   = col_at_end & row_at_end;
                // step the column, wrapping into the row
                if (col_at_end)
                begin
                    nxt.col_count = '0;
                    nxt.row_count = row_at_end ? '0 : cur.row_count + 1'b1;
                end
                else
                begin
                    nxt.col_count = cur.col_count + 1'b1;
                end
            end
            default:
            begin
                nxt.done_pending = pending_or_done;
            end
        endcase
        res.col_mux_lines = nxt.col_lines;
        res.row_mux_lines = nxt.row_lines;
    end

endmodule

>>> hdl/sensor_matrix_scan_sequencer_core.sv
// top level of the sensor matrix scan sequencer: handshake, state and result registers
//
// usage
//   each request on the slave side is one scan tick carrying the converter's
//   done flag and its result register; each tick yields exactly one request on
//   the master side with the mux pin levels after the tick, the start pulse and,
//   in the done phase, the captured sample with its column and row
//   the phase machine walks idle, start, wait and done, one phase per tick
//   wait repeats until a done event
//   tlast marks the sample that completes a full MATRIX_DIM x MATRIX_DIM frame
// timing
//   the result of a tick is in the output register on the cycle after the
//   request is taken
//   throughput is one tick per cycle while m_tready is high, set by the single
//   output register which is refilled in the same cycle it is emptied
// reset
//   phase goes to idle, both counters, the pending-done flag and the mux line
//   images go to zero, and the output register is emptied
// stall
//   while m_tready is low and a result is held, s_tready drops; the held
//   result and the scan state stay unchanged until the receiver takes it
module sensor_matrix_scan_sequencer_core #(
    parameter int MATRIX_DIM = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // conv_done[0], adc_sample[12:1], zero[15:13]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // col_mux_lines[7:0], row_mux_lines[15:8], adc_start[16],
                                   // sample_value[28:17], col_index[33:29],
                                   // row_index[38:34], zero[39]
    output logic        m_tuser,   // sample_valid[0]
    output logic        m_tlast    // frame_last
);

    smss_pkg::smss_state_t  state_reg;
    smss_pkg::smss_state_t  state_next;
    smss_pkg::smss_result_t step_res;
    smss_pkg::smss_result_t res_reg;
    logic                   m_tvalid_reg;
    logic                   accept;

    // output register frees up when empty or being taken this cycle
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    smss_step #(
        .MATRIX_DIM (MATRIX_DIM)
    ) u_step (
        .cur        (state_reg),
        .conv_done  (s_tdata[0]),
        .adc_sample (s_tdata[12:1]),
        .nxt        (state_next),
        .res        (step_res)
    );

    // scan state advances only on a taken tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= smss_pkg::PH_IDLE;
            state_reg.col_count    <= '0;
            state_reg.row_count    <= '0;
            state_reg.done_pending <= 1'b0;
            state_reg.col_lines    <= '0;
            state_reg.row_lines    <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    // result payload, loaded with each taken tick
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= step_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0,
                       res_reg.row_index,
                       res_reg.col_index,
                       res_reg.sample_value,
                       res_reg.adc_start,
                       res_reg.row_mux_lines,
                       res_reg.col_mux_lines};
    assign m_tuser  = res_reg.sample_valid;
    assign m_tlast  = res_reg.frame_last;

endmodule
